[rtl/core/cswm_pkg.sv]
// Package for the C source whitespace minifier.
// Holds lexical mode codes, character constants, payload structs and byte classifiers.
// No dependencies.
package cswm_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_CHAR    = 3'd2,
    MODE_LINE    = 3'd3,
    MODE_BLOCK   = 3'd4,
    MODE_PREPROC = 3'd5
  } mode_e;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  // length of "return"; match count at this value means a complete keyword
  localparam logic [2:0] KW_LEN = 3'd6;

  // result queue depth: one entry in flight plus up to two pushed per transaction
  localparam int unsigned FIFO_DEPTH = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // up to two bytes produced by one transaction
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } emit_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39));
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_LOW_R;
      3'd1:    c = CH_LOW_E;
      3'd2:    c = CH_LOW_T;
      3'd3:    c = CH_LOW_U;
      3'd4:    c = CH_LOW_R;
      3'd5:    c = CH_LOW_N;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_advance(input logic [2:0] cnt, input logic [7:0] b);
    logic [2:0] r;
    if ((cnt < KW_LEN) && (b == kw_char(cnt))) begin
      r = 3'(cnt + 3'd1);
    end else if ((cnt == 3'd5) && (b == CH_LOW_E)) begin
      r = 3'd2;
    end else if (b == CH_LOW_R) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic emit_t put(input emit_t e, input logic [7:0] x);
    emit_t r;
    r = e;
    if (e.n == 2'd0) begin
      r.b0 = x;
      r.n  = 2'd1;
    end else if (e.n == 2'd1) begin
      r.b1 = x;
      r.n  = 2'd2;
    end
    return r;
  endfunction

endpackage

[rtl/core/c_source_whitespace_minifier.sv]
// Top level of the C source whitespace minifier.
// Lexer state, whitespace/keyword rules and a three-entry result queue.
// Depends on cswm_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one text byte per
//   transaction; end_of_text marks the final byte of a text, after which the
//   lexer state returns to its reset values.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns zero, one or
//   two bytes per input transaction; last_of_run flags the final byte of each
//   group. An input that yields nothing produces no output transaction.
//   Each result is written into the registered queue and offered from its head.
//   Throughput: one input byte per cycle while in_ready_o is high; an inserted
//   space costs one extra output transaction, as the output moves one byte per cycle.
//   in_ready_o comes from the queue fill count alone (low with two or more
//   bytes queued), so a stalled receiver backs up the input with no loss.
//   Reset clears lexer state and empties the queue.
module c_source_whitespace_minifier (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cswm_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cswm_pkg::out_t   out_data_o
);
  import cswm_pkg::*;

  mode_e       mode_q, mode_d;
  logic [7:0]  prev_q, prev_d;
  logic        slash_q, slash_d;
  logic        star_q, star_d;
  logic        pend_q, pend_d;
  logic [2:0]  kw_q, kw_d;

  out_t        fifo_q [FIFO_DEPTH];
  out_t        fifo_d [FIFO_DEPTH];
  logic [1:0]  cnt_q, cnt_d;

  logic        acc;
  logic        pop;
  logic [1:0]  base;
  logic [1:0]  push_n;
  emit_t       em;
  logic [7:0]  b;
  logic        done;

  assign b           = in_data_i.in_byte;
  assign in_ready_o  = (cnt_q <= 2'd1);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = fifo_q[0];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    mode_d  = mode_q;
    slash_d = slash_q;
    star_d  = star_q;
    pend_d  = pend_q;
    kw_d    = kw_q;
    em      = '0;
    done    = 1'b0;

    case (mode_q)
      MODE_STRING: begin
        em = put(em, b);
        if ((b == CH_DQUOTE) && (prev_q != CH_BSLASH)) mode_d = MODE_NORMAL;
      end
      MODE_CHAR: begin
        em = put(em, b);
        if ((b == CH_SQUOTE) && (prev_q != CH_BSLASH)) mode_d = MODE_NORMAL;
      end
      MODE_LINE, MODE_PREPROC: begin
        em = put(em, b);
        if (b == CH_LF) mode_d = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        em = put(em, b);
        if (star_q && (b == CH_SLASH)) begin
          mode_d = MODE_NORMAL;
          star_d = 1'b0;
        end else begin
          star_d = (b == CH_STAR);
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
        if ((kw_q == KW_LEN) && !is_alnum(b) && (b != CH_SEMI)) em = put(em, CH_SPACE);
        if (slash_q) begin
          slash_d = 1'b0;
          if ((b == CH_SLASH) || (b == CH_STAR)) begin
            em     = put(em, b);
            mode_d = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            star_d = 1'b0;
            kw_d   = 3'd0;
            done   = 1'b1;
          end
        end
        if (!done && pend_q) begin
          if (is_ws(b)) begin
            done = 1'b1;
          end else begin
            pend_d = 1'b0;
            if (is_letter(b) || (b == CH_HASH)) em = put(em, CH_SPACE);
          end
        end
        if (!done) begin
          if (b == CH_HASH) begin
            em     = put(em, b);
            mode_d = MODE_PREPROC;
            kw_d   = 3'd0;
          end else if (b == CH_DQUOTE) begin
            em     = put(em, b);
            mode_d = MODE_STRING;
            kw_d   = 3'd0;
          end else if (b == CH_SQUOTE) begin
            em     = put(em, b);
            mode_d = MODE_CHAR;
            kw_d   = 3'd0;
          end else if (b == CH_SLASH) begin
            em      = put(em, b);
            slash_d = 1'b1;
            kw_d    = 3'd0;
          end else if (is_ws(b)) begin
            pend_d = 1'b1;
            kw_d   = 3'd0;
          end else begin
            em   = put(em, b);
            kw_d = kw_advance(kw_q, b);
          end
        end
      end
    endcase

    prev_d = b;
    if (in_data_i.end_of_text) begin
      mode_d  = MODE_NORMAL;
      prev_d  = 8'h00;
      slash_d = 1'b0;
      star_d  = 1'b0;
      pend_d  = 1'b0;
      kw_d    = 3'd0;
    end
  end

  // result queue: head at entry 0, shifts down on pop
  assign push_n = acc ? em.n : 2'd0;
  assign base   = 2'(cnt_q - {1'b0, pop});

  always_comb begin
    for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
      fifo_d[i] = pop ? fifo_q[i + 1] : fifo_q[i];
    end
    fifo_d[FIFO_DEPTH - 1] = fifo_q[FIFO_DEPTH - 1];
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if ((push_n != 2'd0) && (base == 2'(i))) begin
        fifo_d[i] = '{out_byte: em.b0, last_of_run: (push_n == 2'd1)};
      end
      if ((push_n == 2'd2) && (2'(base + 2'd1) == 2'(i))) begin
        fifo_d[i] = '{out_byte: em.b1, last_of_run: 1'b1};
      end
    end
    cnt_d = 2'(base + push_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      prev_q  <= 8'h00;
      slash_q <= 1'b0;
      star_q  <= 1'b0;
      pend_q  <= 1'b0;
      kw_q    <= 3'd0;
      cnt_q   <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        mode_q  <= mode_d;
        prev_q  <= prev_d;
        slash_q <= slash_d;
        star_q  <= star_d;
        pend_q  <= pend_d;
        kw_q    <= kw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.end_of_text) |=>
      (mode_q == MODE_NORMAL) && (kw_q == 3'd0) && !pend_q && !slash_q)
    else $error("lexer state not cleared after end of text");

  a_slash_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(slash_q && pend_q))
    else $error("slash and pending space both set");

  a_pend_kw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (kw_q == 3'd0))
    else $error("keyword match active during whitespace run");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> (cnt_q == 2'($past(cnt_q) - {1'b0, $past(pop)})))
    else $error("queue count changed without a transaction");

endmodule

[bench/cswm_output_checker.sv]
`timescale 1ns / 1ps
// Output checker for c_source_whitespace_minifier: predicts the minified byte stream
// from accepted input transactions and compares it with accepted output transactions.
// Depends on cswm_pkg.
module cswm_output_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cswm_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cswm_pkg::out_t out_data_i,
  output int             mismatch_count_o,
  output int             pending_count_o,
  output int             checked_count_o
);
  import cswm_pkg::*;

  localparam string KEYWORD_TEXT = "return";

  mode_e      lex_mode;
  logic [7:0] prev_byte;
  logic       slash_open;
  logic       star_open;
  logic       blank_run;
  logic [2:0] kw_count;
  out_t       expected_bytes[$];

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_alnum_char(input logic [7:0] c);
    return is_alpha(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic [2:0] next_keyword_count(input logic [2:0] cnt, input logic [7:0] c);
    if (cnt < 3'd6 && c == KEYWORD_TEXT[cnt]) return cnt + 3'd1;
    if (cnt == 3'd5 && c == CH_LOW_E) return 3'd2;
    return (c == CH_LOW_R) ? 3'd1 : 3'd0;
  endfunction

  task automatic reset_predictor();
    lex_mode   = MODE_NORMAL;
    prev_byte  = 8'h00;
    slash_open = 1'b0;
    star_open  = 1'b0;
    blank_run  = 1'b0;
    kw_count   = 3'd0;
  endtask

  task automatic predict_minified(input in_t txn);
    logic [7:0] b;
    logic [7:0] emitted[$];
    logic       handled;
    int         n;
    b = txn.in_byte;
    handled = 1'b0;
    case (lex_mode)
      MODE_STRING: begin
        emitted.push_back(b);
        if (b == CH_DQUOTE && prev_byte != CH_BSLASH) lex_mode = MODE_NORMAL;
      end
      MODE_CHAR: begin
        emitted.push_back(b);
        if (b == CH_SQUOTE && prev_byte != CH_BSLASH) lex_mode = MODE_NORMAL;
      end
      MODE_LINE, MODE_PREPROC: begin
        emitted.push_back(b);
        if (b == CH_LF) lex_mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        emitted.push_back(b);
        if (star_open && b == CH_SLASH) begin
          lex_mode  = MODE_NORMAL;
          star_open = 1'b0;
        end else begin
          star_open = (b == CH_STAR);
        end
      end
      default: begin
        lex_mode = MODE_NORMAL;
        if (kw_count == 3'd6 && !is_alnum_char(b) && b != CH_SEMI) emitted.push_back(CH_SPACE);
        if (slash_open) begin
          slash_open = 1'b0;
          if (b == CH_SLASH || b == CH_STAR) begin
            emitted.push_back(b);
            lex_mode  = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            star_open = 1'b0;
            kw_count  = 3'd0;
            handled   = 1'b1;
          end
        end
        if (!handled && blank_run) begin
          if (is_blank(b)) begin
            handled = 1'b1;
          end else begin
            blank_run = 1'b0;
            if (is_alpha(b) || b == CH_HASH) emitted.push_back(CH_SPACE);
          end
        end
        if (!handled) begin
          if (is_blank(b)) begin
            blank_run = 1'b1;
            kw_count  = 3'd0;
          end else begin
            emitted.push_back(b);
            case (b)
              CH_HASH: begin
                lex_mode = MODE_PREPROC;
                kw_count = 3'd0;
              end
              CH_DQUOTE: begin
                lex_mode = MODE_STRING;
                kw_count = 3'd0;
              end
              CH_SQUOTE: begin
                lex_mode = MODE_CHAR;
                kw_count = 3'd0;
              end
              CH_SLASH: begin
                slash_open = 1'b1;
                kw_count   = 3'd0;
              end
              default: kw_count = next_keyword_count(kw_count, b);
            endcase
          end
        end
      end
    endcase
    prev_byte = b;
    n = (emitted.size() > 2) ? 2 : emitted.size();
    for (int i = 0; i < n; i++) begin
      expected_bytes.push_back('{out_byte: emitted[i], last_of_run: (i == n - 1)});
    end
    if (txn.end_of_text) reset_predictor();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t oldest;
    if (!rst_ni) begin
      reset_predictor();
      expected_bytes.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      checked_count_o  = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_minified(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h", out_data_i.out_byte);
          mismatch_count_o++;
        end else begin
          oldest = expected_bytes.pop_front();
          checked_count_o++;
          if (out_data_i.out_byte !== oldest.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   oldest.out_byte, out_data_i.out_byte);
            mismatch_count_o++;
          end
          if (out_data_i.last_of_run !== oldest.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   oldest.last_of_run, out_data_i.last_of_run);
            mismatch_count_o++;
          end
        end
      end
      pending_count_o = expected_bytes.size();
    end
  end

endmodule

[bench/c_source_whitespace_minifier_tb.sv]
`timescale 1ns / 1ps
// Testbench top for c_source_whitespace_minifier: clock, reset, C-like text stimulus
// with random idling on both channels, and the verdict.
// Depends on cswm_pkg and cswm_output_checker.
module c_source_whitespace_minifier_tb;
  import cswm_pkg::*;

  localparam int    TOTAL_BYTES = 1750;
  localparam string WORD_CHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_rte";
  localparam string BLANK_CHARS = " \t\n\r";
  localparam string PUNCT_CHARS = ";(){}[]+-*/=<>,.!&|";
  localparam string CMT_CHARS   = " *a/*b";

  typedef enum int {
    TOK_WORD, TOK_KEYWORD, TOK_BLANKS, TOK_STRING, TOK_CHAR,
    TOK_LINE_CMT, TOK_BLOCK_CMT, TOK_DIRECTIVE, TOK_PUNCT, TOK_NOISE
  } token_kind_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  int         send_idle_pct = 24;
  int         recv_idle_pct = 45;
  int         bytes_sent    = 0;
  int         texts_sent    = 0;
  int         mismatch_count;
  int         pending_count;
  int         checked_count;
  logic [7:0] text_q[$];

  always #2 clk_i = ~clk_i;

  c_source_whitespace_minifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  cswm_output_checker u_output_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  always @(negedge clk_i) begin
    out_ready_i <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (bytes_sent < TOTAL_BYTES / 3) begin
      send_idle_pct = 24;
      recv_idle_pct = 45;
    end else if (bytes_sent < 2 * TOTAL_BYTES / 3) begin
      send_idle_pct = 45;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, end_of_text: eot};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // printable byte that cannot close or escape a literal
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) c = "a";
    return c;
  endfunction

  task automatic add_token();
    token_kind_e kind;
    int          len;
    kind = token_kind_e'($urandom_range(TOK_NOISE));
    len  = $urandom_range(1, 6);
    case (kind)
      TOK_WORD: begin
        repeat (len) text_q.push_back(WORD_CHARS[$urandom_range(WORD_CHARS.len() - 1)]);
      end
      TOK_KEYWORD: begin
        case ($urandom_range(3))
          0:       push_text("return");
          1:       push_text("retreturn");
          2:       push_text("returne");
          default: push_text("rreturn");
        endcase
      end
      TOK_BLANKS: begin
        repeat (len) text_q.push_back(BLANK_CHARS[$urandom_range(3)]);
      end
      TOK_STRING: begin
        text_q.push_back(CH_DQUOTE);
        repeat (len) begin
          if ($urandom_range(3) == 0) text_q.push_back(CH_BSLASH);
          text_q.push_back(($urandom_range(4) == 0) ? CH_DQUOTE : plain_char());
        end
        text_q.push_back(CH_DQUOTE);
      end
      TOK_CHAR: begin
        text_q.push_back(CH_SQUOTE);
        if ($urandom_range(2) == 0) text_q.push_back(CH_BSLASH);
        text_q.push_back(($urandom_range(3) == 0) ? CH_SQUOTE : plain_char());
        text_q.push_back(CH_SQUOTE);
      end
      TOK_LINE_CMT: begin
        push_text("//");
        repeat (len) text_q.push_back(plain_char());
        text_q.push_back(CH_LF);
      end
      TOK_BLOCK_CMT: begin
        push_text("/*");
        repeat (len) text_q.push_back(CMT_CHARS[$urandom_range(CMT_CHARS.len() - 1)]);
        push_text("*/");
      end
      TOK_DIRECTIVE: begin
        text_q.push_back(CH_HASH);
        repeat (len) text_q.push_back(plain_char());
        text_q.push_back(CH_LF);
      end
      TOK_PUNCT: begin
        repeat ($urandom_range(1, 2))
          text_q.push_back(PUNCT_CHARS[$urandom_range(PUNCT_CHARS.len() - 1)]);
      end
      default: text_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  initial begin
    logic [7:0] b;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_text("return(", 1'b0);
    send_text("\t\n#", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_text("/*/*/", 1'b0);
    send_text("'\\''", 1'b0);
    send_text("//\n", 1'b0);
    send_text("return", 1'b1);
    send_text(" ", 1'b1);

    while (bytes_sent < TOTAL_BYTES) begin
      if (text_q.size() == 0) add_token();
      b = text_q.pop_front();
      send_byte(b, $urandom_range(59) == 0);
    end
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Sent %0d text bytes, %0d of them closing a text; compared %0d output bytes.",
             bytes_sent, texts_sent, checked_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
